>>> rtl/core/vip_pkg.sv
// Shared constants, codes and types for the volume intensity projection block.
// No dependencies.
package vip_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WIDTH_DEF   = 512;
    localparam int MAX_HEIGHT_DEF  = 512;
    localparam int MAX_DEPTH_DEF   = 1024;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_AXIS   = 3'd1;
    localparam logic [2:0] CFG_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_DEPTH  = 3'd4;
    localparam logic [2:0] CFG_SIGNED = 3'd5;

    localparam logic [1:0] MODE_MAX  = 2'd0;
    localparam logic [1:0] MODE_MIN  = 2'd1;
    localparam logic [1:0] MODE_MEAN = 2'd2;

    localparam logic [1:0] AXIS_SLICE  = 2'd0;
    localparam logic [1:0] AXIS_ROW    = 2'd1;
    localparam logic [1:0] AXIS_COLUMN = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

    // zero counts as one, anything above the maximum is the maximum
    function automatic int clamp_size(input int v, input int maxv);
        int r;
        r = v;
        if (v == 0) r = 1;
        else if (v > maxv) r = maxv;
        return r;
    endfunction

endpackage

>>> rtl/core/vip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/volume_intensity_projection.sv
// Volume intensity projection: max, min or rounded mean along one axis.
// Uses vip_pkg and vip_ram.
//
// Voxels arrive in raster order and each one is taken in its own pass: the
// read of its ray accumulator from the buffer RAM as it is accepted, then the
// update and write back in S_CALC. A voxel that closes a ray then loads the
// output register from S_OUT, in mean mode after the bit-serial restoring
// divider in S_DIV. The output register lets the next voxel enter while a
// pixel waits; a second closing voxel waits for it to be taken. The buffer
// needs no clearing after reset since the first voxel of a ray writes it.
module volume_intensity_projection
    import vip_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_voxel_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_bits,
    output logic [8:0]  o_out_column,
    output logic [9:0]  o_out_row,
    output logic        o_image_done
);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int LEN_W = (WW > HW) ? ((WW > DW) ? WW : DW) : ((HW > DW) ? HW : DW);
    localparam int ACC_W = SAMPLE_BITS + LEN_W + 1;
    localparam int NUM_W = ACC_W + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = WW + HW;
    localparam int XW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

    t_state r_state, n_state;

    logic [1:0]    r_mode, r_axis;
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [DW-1:0] r_depth;
    logic          r_signed;
    logic [WW-1:0] r_col;
    logic [HW-1:0] r_row;
    logic [DW-1:0] r_slice;

    logic signed [ACC_W-1:0] r_v;
    logic [AW-1:0]           r_idx;
    logic                    r_first, r_emit, r_last;
    logic [LEN_W-1:0]        r_len;
    logic [8:0]              r_ocol;
    logic [9:0]              r_orow;
    logic [SAMPLE_BITS-1:0]  r_res;
    logic [NUM_W-1:0]        r_q, r_rem;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;

    logic accept, cfg_hit;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign cfg_hit = i_cfg_we && (i_cfg_index <= CFG_SIGNED);

    // per-voxel geometry
    logic [XW-1:0]          raw;
    logic [SAMPLE_BITS-1:0] bits;
    logic signed [ACC_W-1:0] v;
    logic [LEN_W-1:0] pos, len;
    logic [PW-1:0]    prod;
    logic [AW-1:0]    idx;
    logic [9:0]       ocol_w, orow_w;
    logic             last_col, last_row, last_slice;

    assign raw  = XW'(i_voxel_bits);
    assign bits = raw[SAMPLE_BITS-1:0];
    assign v    = (r_signed && bits[SAMPLE_BITS-1]) ?
                  ACC_W'($signed(bits)) : ACC_W'($unsigned(bits));
    assign prod = PW'(r_row) * PW'(r_width) + PW'(r_col);
    assign last_col   = (WW'(r_col + 1'b1) >= r_width) || (&r_col);
    assign last_row   = (HW'(r_row + 1'b1) >= r_height) || (&r_row);
    assign last_slice = (DW'(r_slice + 1'b1) >= r_depth) || (&r_slice);

    always_comb begin
        case (r_axis)
            AXIS_ROW: begin
                idx = AW'(r_col); pos = LEN_W'(r_row); len = LEN_W'(r_height);
                ocol_w = 10'(r_col); orow_w = 10'(r_slice);
            end
            AXIS_COLUMN: begin
                idx = '0; pos = LEN_W'(r_col); len = LEN_W'(r_width);
                ocol_w = 10'(r_row); orow_w = 10'(r_slice);
            end
            default: begin
                idx = AW'(prod); pos = LEN_W'(r_slice); len = LEN_W'(r_depth);
                ocol_w = 10'(r_col); orow_w = 10'(r_row);
            end
        endcase
    end

    // accumulator buffer
    logic [ACC_W-1:0] rdata;
    logic signed [ACC_W-1:0] rd, acc;
    vip_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC),
        .i_waddr (r_idx),
        .i_wdata (acc),
        .i_re    (accept),
        .i_raddr (idx),
        .o_rdata (rdata)
    );
    assign rd = $signed(rdata);

    always_comb begin
        if (r_first) acc = r_v;
        else begin
            case (r_mode)
                MODE_MEAN: acc = rd + r_v;
                MODE_MIN:  acc = (r_v < rd) ? r_v : rd;
                default:   acc = (r_v > rd) ? r_v : rd;
            endcase
        end
    end

    // rounded mean: (2*sum + n) / (2*n), truncated toward zero
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0] den, rem_sh, rem_nx, q_nx, qs;
    logic             qbit;
    assign num    = ($signed(NUM_W'(acc)) <<< 1) + $signed(NUM_W'(r_len));
    assign den    = NUM_W'({r_len, 1'b0});
    assign rem_sh = {r_rem[NUM_W-2:0], r_q[NUM_W-1]};
    assign qbit   = (rem_sh >= den);
    assign rem_nx = qbit ? rem_sh - den : rem_sh;
    assign q_nx   = {r_q[NUM_W-2:0], qbit};
    assign qs     = r_neg ? -q_nx : q_nx;

    logic out_free;
    assign out_free = !o_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_CALC;
            S_CALC: begin
                if (!r_emit) n_state = S_IDLE;
                else if (r_mode == MODE_MEAN) n_state = S_DIV;
                else n_state = S_OUT;
            end
            S_DIV:  if (r_cnt == CNT_W'(NUM_W - 1)) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // configuration and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MAX;
            r_axis   <= AXIS_SLICE;
            r_width  <= WW'(clamp_size(512, MAX_WIDTH));
            r_height <= HW'(clamp_size(512, MAX_HEIGHT));
            r_depth  <= DW'(clamp_size(1024, MAX_DEPTH));
            r_signed <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_slice  <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_AXIS:   r_axis   <= (i_cfg_data[1:0] == 2'd3) ? AXIS_SLICE
                                                                  : i_cfg_data[1:0];
                CFG_WIDTH:  r_width  <= WW'(clamp_size(int'(i_cfg_data[9:0]), MAX_WIDTH));
                CFG_HEIGHT: r_height <= HW'(clamp_size(int'(i_cfg_data[9:0]), MAX_HEIGHT));
                CFG_DEPTH:  r_depth  <= DW'(clamp_size(int'(i_cfg_data), MAX_DEPTH));
                default:    r_signed <= i_cfg_data[0];
            endcase
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
        end else if (accept) begin
            if (!last_col) r_col <= WW'(r_col + 1'b1);
            else begin
                r_col <= '0;
                if (!last_row) r_row <= HW'(r_row + 1'b1);
                else begin
                    r_row   <= '0;
                    r_slice <= last_slice ? '0 : DW'(r_slice + 1'b1);
                end
            end
        end
    end

    // voxel capture, update and divider datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v     <= v;
            r_idx   <= idx;
            r_first <= (pos == '0);
            r_emit  <= (LEN_W'(pos + 1'b1) >= len) || (&pos);
            r_last  <= last_col && last_row && last_slice;
            r_len   <= len;
            r_ocol  <= ocol_w[8:0];
            r_orow  <= orow_w;
        end
        case (r_state)
            S_CALC: begin
                r_res <= acc[SAMPLE_BITS-1:0];
                r_neg <= num[NUM_W-1];
                r_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_q   <= q_nx;
                r_rem <= rem_nx;
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(NUM_W - 1)) r_res <= qs[SAMPLE_BITS-1:0];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (r_state == S_OUT && out_free) o_valid <= 1'b1;
        else if (i_ready) o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            o_pixel_bits <= 16'(r_res);
            o_out_column <= r_ocol;
            o_out_row    <= r_orow;
            o_image_done <= r_last;
        end
    end
endmodule

>>> rtl/core/vip_checker.sv
// Port-level assertions for volume_intensity_projection, bound to the top level.
// Depends on volume_intensity_projection.
module vip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_pixel_bits,
    input logic        o_image_done
);
    // a pending word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_bits) && $stable(o_image_done))
        else $error("output word changed while stalled");

    // each accepted voxel is worked on before the next is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted on consecutive cycles");

    // a voxel taken while no pixel is pending yields no pixel straight away
    a_no_instant_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("pixel appeared too early");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");
endmodule

bind volume_intensity_projection vip_checker u_vip_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pixel_bits (o_pixel_bits),
    .o_image_done (o_image_done)
);

>>> tb/testbench.sv
// Self-checking bench for volume_intensity_projection: directed table, then random volumes.
// Depends on vip_pkg and the block RTL; predicts every pixel from its own model of the block.
module testbench;
    import vip_pkg::*;

    typedef struct {
        logic [15:0] pix;
        logic [8:0]  col;
        logic [9:0]  row;
        logic        done;
    } t_pixel;

    typedef struct {
        bit          is_voxel;
        logic [2:0]  idx;
        logic [10:0] data;
        logic [15:0] voxel;
        bit          typed;
        logic [15:0] pix;
    } t_row;

    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCH_LIMIT  = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_voxel_bits = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_pixel_bits;
    logic [8:0]  o_out_column;
    logic [9:0]  o_out_row;
    logic        o_image_done;

    volume_intensity_projection uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    longint    ray_acc [int];
    int        col_cnt, row_cnt, slc_cnt;
    logic [1:0] mode_q, axis_q;
    int        width_q, height_q, depth_q;
    bit        signed_q;

    t_pixel    pending_pixels [$];
    int        errors = 0;
    int        send_pct = 0;
    int        stall_pct = 0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    bit        running = 1'b0;

    function automatic int size_clamp(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic model_reset();
        ray_acc.delete();
        col_cnt = 0; row_cnt = 0; slc_cnt = 0;
        mode_q = MODE_MAX; axis_q = AXIS_SLICE;
        width_q = 512; height_q = 512; depth_q = 1024;
        signed_q = 1'b0;
    endtask

    task automatic model_write(logic [2:0] idx, logic [10:0] data);
        case (idx)
            CFG_MODE:   mode_q = data[1:0];
            CFG_AXIS:   axis_q = data[1:0];
            CFG_WIDTH:  width_q = size_clamp(int'(data[9:0]), MAX_WIDTH_DEF);
            CFG_HEIGHT: height_q = size_clamp(int'(data[9:0]), MAX_HEIGHT_DEF);
            CFG_DEPTH:  depth_q = size_clamp(int'(data[10:0]), MAX_DEPTH_DEF);
            CFG_SIGNED: signed_q = data[0];
            default:    return;
        endcase
        col_cnt = 0; row_cnt = 0; slc_cnt = 0;
    endtask

    // advance the ray model by one voxel; returns 1 with the pixel when a ray closes
    function automatic bit project_voxel(logic [15:0] vb, output t_pixel px);
        int idx, pos, len, ocol, orow;
        longint v, acc, res, n;
        bit last, closes;
        last = (col_cnt + 1 >= width_q) && (row_cnt + 1 >= height_q) &&
               (slc_cnt + 1 >= depth_q);
        v = (signed_q && vb[15]) ? longint'(vb) - 65536 : longint'(vb);
        if (axis_q == AXIS_ROW) begin
            idx = col_cnt; pos = row_cnt; len = height_q; ocol = col_cnt; orow = slc_cnt;
        end else if (axis_q == AXIS_COLUMN) begin
            idx = 0; pos = col_cnt; len = width_q; ocol = row_cnt; orow = slc_cnt;
        end else begin
            idx = row_cnt * width_q + col_cnt; pos = slc_cnt; len = depth_q;
            ocol = col_cnt; orow = row_cnt;
        end
        if (pos == 0) begin
            acc = v;
        end else begin
            acc = ray_acc[idx];
            if (mode_q == MODE_MEAN) acc = acc + v;
            else if (mode_q == MODE_MIN) begin
                if (v < acc) acc = v;
            end else if (v > acc) acc = v;
        end
        ray_acc[idx] = acc;
        closes = (pos + 1 >= len);
        res = acc;
        if (mode_q == MODE_MEAN) begin
            n = len;
            res = (2 * acc + n) / (2 * n);
        end
        px.pix = res[15:0];
        px.col = ocol[8:0];
        px.row = orow[9:0];
        px.done = last;
        if (col_cnt + 1 < width_q) col_cnt = col_cnt + 1;
        else begin
            col_cnt = 0;
            if (row_cnt + 1 < height_q) row_cnt = row_cnt + 1;
            else begin
                row_cnt = 0;
                slc_cnt = (slc_cnt + 1 < depth_q) ? slc_cnt + 1 : 0;
            end
        end
        return closes;
    endfunction

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // pixel checker
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel %h at (%0d,%0d)", o_pixel_bits, o_out_column, o_out_row);
                errors = errors + 1;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_bits !== want.pix) begin
                    $error("pixel_bits expected %h got %h", want.pix, o_pixel_bits);
                    errors = errors + 1;
                end
                if (o_out_column !== want.col) begin
                    $error("out_column expected %0d got %0d", want.col, o_out_column);
                    errors = errors + 1;
                end
                if (o_out_row !== want.row) begin
                    $error("out_row expected %0d got %0d", want.row, o_out_row);
                    errors = errors + 1;
                end
                if (o_image_done !== want.done) begin
                    $error("image_done expected %b got %b", want.done, o_image_done);
                    errors = errors + 1;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!running || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [10:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_write(idx, data);
    endtask

    // offer one word; with a typed value it overrides the predicted pixel value
    task automatic send_voxel(logic [15:0] vb, bit typed, logic [15:0] typed_pix);
        t_pixel px;
        if (send_pct > 0 && $urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_voxel_bits <= vb;
        do @(posedge i_clk); while (!o_ready);
        if (project_voxel(vb, px)) begin
            if (typed) px.pix = typed_pix;
            pending_pixels.push_back(px);
        end
    endtask

    task automatic set_idling(int phase);
        case (phase)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 75; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 75; end
            default: begin send_pct = 18; stall_pct = 18; end
        endcase
    endtask

    function automatic logic [10:0] junk_above(int keep_bits, int value);
        logic [10:0] r;
        r = 11'($urandom);
        for (int b = 0; b < keep_bits; b++) r[b] = 1'b0;
        return r | 11'(value);
    endfunction

    t_row dir_rows [$];

    initial begin
        int total;
        int w, h, d, nvox, pick;
        bit fill_ext;
        model_reset();
        // single-voxel rays, extremes
        dir_rows.push_back('{0, CFG_WIDTH,  11'd1, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_HEIGHT, 11'd1, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_DEPTH,  11'd1, 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'hFFFF, 1, 16'hFFFF});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h0000, 1, 16'h0000});
        // signed min/max across the sign boundary
        dir_rows.push_back('{0, CFG_DEPTH,  11'd2, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_SIGNED, 11'd1, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_MODE, 11'(MODE_MIN), 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h7FFF, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h8000, 1, 16'h8000});
        dir_rows.push_back('{0, CFG_MODE, 11'(MODE_MAX), 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h8000, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h7FFF, 1, 16'h7FFF});
        dir_rows.push_back('{0, CFG_SIGNED, 11'd0, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_MODE, 11'(MODE_MIN), 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h8000, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h7FFF, 1, 16'h7FFF});
        // mean, unsigned full scale then signed negatives
        dir_rows.push_back('{0, CFG_MODE, 11'(MODE_MEAN), 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'hFFFF, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'hFFFF, 1, 16'hFFFF});
        dir_rows.push_back('{0, CFG_SIGNED, 11'd1, 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'hFFFF, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'hFFFE, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h0003, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h0002, 0, 16'h0});
        // unused mode and axis codes, a zero size, indices past the list
        dir_rows.push_back('{0, CFG_MODE, 11'd3, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_AXIS, 11'd3, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_WIDTH, 11'd2, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_HEIGHT, 11'd0, 16'h0, 0, 16'h0});
        dir_rows.push_back('{0, CFG_DEPTH, 11'd2, 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h0005, 0, 16'h0});
        dir_rows.push_back('{0, 3'd6, 11'h7FF, 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h8001, 0, 16'h0});
        dir_rows.push_back('{0, 3'd7, 11'h000, 16'h0, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h1234, 0, 16'h0});
        dir_rows.push_back('{1, 3'd0, 11'd0, 16'h0042, 0, 16'h0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_voxel) begin
                send_voxel(dir_rows[k].voxel, dir_rows[k].typed, dir_rows[k].pix);
            end else begin
                i_valid <= 1'b0;
                wait_idle();
                cfg_write(dir_rows[k].idx, dir_rows[k].data);
            end
        end

        total = 0;
        for (int ph = 0; total < 550 || ph < 16; ph++) begin
            i_valid <= 1'b0;
            wait_idle();
            set_idling(ph % 4);
            pick = $urandom_range(19);
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 5);
            d = $urandom_range(1, 5);
            // enough closing voxels to fill the block during the hold-off
            if (ph == 4) begin
                w = 5; h = 5; d = 1; pick = 3;
            end
            cfg_write(CFG_MODE, junk_above(2, $urandom_range(3)));
            cfg_write(CFG_AXIS, junk_above(2, $urandom_range(3)));
            cfg_write(CFG_WIDTH, junk_above(10, w));
            cfg_write(CFG_HEIGHT, junk_above(10, h));
            cfg_write(CFG_DEPTH, 11'(d));
            cfg_write(CFG_SIGNED, junk_above(1, $urandom_range(1)));
            if (pick == 0) cfg_write(3'($urandom_range(6, 7)), 11'($urandom));
            nvox = width_q * height_q * depth_q;
            // some volumes cut short, some run into a second pass
            if (pick == 1) nvox = $urandom_range(1, nvox);
            else if (pick == 2) nvox = nvox + $urandom_range(1, nvox);
            fill_ext = ($urandom_range(5) == 0);
            if (ph == 4) hold_req = hold_req + 1;
            for (int k = 0; k < nvox; k++) begin
                if (fill_ext) send_voxel($urandom_range(1) ? 16'hFFFF : 16'h8000, 0, 16'h0);
                else send_voxel(16'($urandom), 0, 16'h0);
            end
            total = total + nvox;
        end

        i_valid <= 1'b0;
        wait_idle();
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> volume_intensity_projection.f
rtl/core/vip_pkg.sv
rtl/core/vip_ram.sv
rtl/core/volume_intensity_projection.sv
rtl/core/vip_checker.sv
tb/testbench.sv
